// ----- src/simple9_word_packer_top_assert.svh -----
// Assertion macros used by the packer's checker file.
`ifndef SIMPLE9_WORD_PACKER_TOP_ASSERT_SVH
`define SIMPLE9_WORD_PACKER_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define S9WP_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define S9WP_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also runs through reset.
`define S9WP_CHECK_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/s9wp_pkg.sv -----
// Types, constants and table functions of the Simple-9 word packer.
package s9wp_pkg;

  localparam logic [4:0]  SLOTS          = 5'd28;
  localparam logic [10:0] PAYLOAD_LIMIT  = 11'd28;
  localparam logic [29:0] CAPACITY_RESET = 30'h3FFF_FFFF;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_CAPACITY  = 2'd2
  } status_t;

  // Classified integer handed from the front to the back.
  typedef struct packed {
    logic [27:0] value;
    logic [4:0]  width;
    logic        last;
    logic        too_large;
  } item_t;

  // Packing width of an integer that fits in 28 bits.
  function automatic logic [4:0] width_of(input logic [27:0] v);
    logic [4:0] w;
    if (v < 28'd2)          w = 5'd1;
    else if (v < 28'd4)     w = 5'd2;
    else if (v < 28'd8)     w = 5'd3;
    else if (v < 28'd16)    w = 5'd4;
    else if (v < 28'd32)    w = 5'd5;
    else if (v < 28'd128)   w = 5'd7;
    else if (v < 28'd512)   w = 5'd9;
    else if (v < 28'd16384) w = 5'd14;
    else                    w = 5'd28;
    return w;
  endfunction

  // Selector row with the largest count that does not exceed the fitting integers;
  // twenty-seven fitting integers also take the 28-slot row.
  function automatic logic [3:0] row_for_fit(input logic [4:0] fit);
    logic [3:0] r;
    if (fit >= 5'd27)      r = 4'd8;
    else if (fit >= 5'd14) r = 4'd7;
    else if (fit >= 5'd9)  r = 4'd6;
    else if (fit >= 5'd7)  r = 4'd5;
    else if (fit >= 5'd5)  r = 4'd4;
    else if (fit >= 5'd4)  r = 4'd3;
    else if (fit >= 5'd3)  r = 4'd2;
    else if (fit >= 5'd2)  r = 4'd1;
    else                   r = 4'd0;
    return r;
  endfunction

  function automatic logic [4:0] row_count(input logic [3:0] row);
    logic [4:0] n;
    case (row)
      4'd0:    n = 5'd1;
      4'd1:    n = 5'd2;
      4'd2:    n = 5'd3;
      4'd3:    n = 5'd4;
      4'd4:    n = 5'd5;
      4'd5:    n = 5'd7;
      4'd6:    n = 5'd9;
      4'd7:    n = 5'd14;
      4'd8:    n = 5'd28;
      default: n = 5'd1;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] row_bits(input logic [3:0] row);
    logic [4:0] b;
    case (row)
      4'd0:    b = 5'd28;
      4'd1:    b = 5'd14;
      4'd2:    b = 5'd9;
      4'd3:    b = 5'd7;
      4'd4:    b = 5'd5;
      4'd5:    b = 5'd4;
      4'd6:    b = 5'd3;
      4'd7:    b = 5'd2;
      4'd8:    b = 5'd1;
      default: b = 5'd28;
    endcase
    return b;
  endfunction

  // Slot index of a circular 28-entry buffer.
  function automatic logic [4:0] slot_add(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, SLOTS}) s = s - {1'b0, SLOTS};
    return s[4:0];
  endfunction

endpackage

// ----- src/s9wp_if.sv -----
// Handshake interfaces for the integer input and the code word output.
interface s9wp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        list_end;
  modport source (output valid, output value, output list_end, input ready);
  modport sink   (input valid, input value, input list_end, output ready);
endinterface

interface s9wp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;
  logic [1:0]  status;
  logic        run_last;
  modport source (output valid, output code_word, output status, output run_last,
                  input ready);
  modport sink   (input valid, input code_word, input status, input run_last,
                  output ready);
endinterface

// ----- src/simple9_word_packer_top.sv -----
// Top level of the Simple-9 word packer.
//
//   port     dir   handshake      payload
//   items    in    valid/ready    value[31:0], list_end
//   words    out   valid/ready    code_word[31:0], status[1:0], run_last
//   cfg      in    cfg_we         cfg_wdata[29:0] = capacity_words
//
// The front registers and classifies one integer per cycle, while the queue has
// room, into a short queue. The back buffers an integer that completes no word
// directly. A completed word passes a capacity check, a packing step for each
// integer, a rescan of the leftover entries and a release step for the word;
// the 28-entry buffer has a single read port and is read one entry at a time.
// Reset is synchronous and clears the state, pointers, counters and valid flags.
// A stalled output holds the back, and the queue then fills and holds the input.
module simple9_word_packer_top import s9wp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  s9wp_in_if.sink     items,
  s9wp_out_if.source  words,
  input  logic        cfg_we,
  input  logic [29:0] cfg_wdata
);

  logic [29:0] capacity;
  logic        f_valid;
  item_t       f_item;
  logic        f_ready;
  logic        q_valid;
  item_t       q_item;
  logic        q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  s9wp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  s9wp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_item  (f_item),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  s9wp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .capacity (capacity),
    .words    (words)
  );

endmodule

// ----- src/s9wp_front.sv -----
// Front stage: accepts integers and classifies width and range.
module s9wp_front import s9wp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  s9wp_in_if.sink       items,
  output logic          item_valid,
  output item_t         item,
  input  logic          item_ready
);

  logic  held;
  item_t held_item;

  assign items.ready = !held || item_ready;
  assign item_valid  = held;
  assign item        = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      if (items.valid && items.ready) begin
        held                <= 1'b1;
        held_item.value     <= items.value[27:0];
        held_item.width     <= width_of(items.value[27:0]);
        held_item.last      <= items.list_end;
        held_item.too_large <= (items.value[31:28] != 4'd0);
      end else if (item_ready) begin
        held <= 1'b0;
      end
    end
  end

endmodule

// ----- src/s9wp_queue.sv -----
// Short queue of classified integers between front and back.
module s9wp_queue import s9wp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule

// ----- src/s9wp_back.sv -----
// Back sequencer: buffers integers, picks selector rows and packs words.
module s9wp_back import s9wp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  input  logic [29:0] capacity,
  s9wp_out_if.source  words
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_CAP,
    ST_PACK
  } state_t;

  state_t      state;
  logic [27:0] buf_value [28];
  logic [4:0]  buf_width [28];

  logic [4:0]  head;
  logic [4:0]  count;
  logic [4:0]  scanned;
  logic [4:0]  need;
  logic [4:0]  fit;
  logic [29:0] words_emitted;
  logic        drop;
  logic        last_r;
  logic        another;
  logic        has_word;
  logic [31:0] word_r;
  logic [3:0]  row_r;
  logic [4:0]  pack_i;
  logic [4:0]  pack_n;
  logic [4:0]  pack_b;
  logic [4:0]  pack_off;
  logic [27:0] payload;

  logic        out_valid;
  logic [31:0] out_word;
  status_t     out_status;
  logic        out_last;

  logic        out_free;
  logic        out_load;
  logic [4:0]  need_in;
  logic [5:0]  count_p1;
  logic [10:0] prod_in;
  logic        over_in;
  logic [4:0]  rd_addr;
  logic [4:0]  wr_addr;
  logic [27:0] rd_value;
  logic [4:0]  rd_width;
  logic [4:0]  need_sc;
  logic [10:0] prod_sc;
  logic [27:0] payload_next;
  logic [3:0]  cap_row;
  logic [4:0]  cap_n;
  logic        take_item;

  assign words.valid     = out_valid;
  assign words.code_word = out_word;
  assign words.status    = out_status;
  assign words.run_last  = out_last;

  assign out_free = !out_valid || words.ready;

  // Incoming integer against the running maximum width.
  assign need_in  = (q_item.width > need) ? q_item.width : need;
  assign count_p1 = {1'b0, count} + 6'd1;
  assign prod_in  = {6'd0, need_in} * {5'd0, count_p1};
  assign over_in  = (prod_in > PAYLOAD_LIMIT);

  assign wr_addr  = slot_add(head, count);
  assign rd_addr  = slot_add(head, (state == ST_PACK) ? pack_i : scanned);
  assign rd_value = buf_value[rd_addr];
  assign rd_width = buf_width[rd_addr];

  assign need_sc  = (rd_width > need) ? rd_width : need;
  assign prod_sc  = {6'd0, need_sc} * {6'd0, scanned + 5'd1};

  assign payload_next = payload | (rd_value << pack_off);
  assign cap_row      = row_for_fit(fit);
  // Never pack past the buffered entries.
  assign cap_n        = (row_count(cap_row) > count) ? count : row_count(cap_row);

  always_comb begin
    q_pop = 1'b0;
    if (state == ST_IDLE && q_valid) begin
      if (drop || !q_item.too_large) q_pop = 1'b1;
      else                           q_pop = out_free;
    end
  end

  // A new result enters the output register this cycle.
  always_comb begin
    out_load = 1'b0;
    if (out_free) begin
      if (state == ST_IDLE)         out_load = q_valid && !drop && q_item.too_large;
      else if (state == ST_RESOLVE) out_load = has_word;
      else if (state == ST_CAP)     out_load = (words_emitted >= capacity);
    end
  end

  assign take_item = q_pop && !drop && !q_item.too_large;

  always_ff @(posedge clk) begin
    if (take_item) begin
      buf_value[wr_addr] <= q_item.value;
      buf_width[wr_addr] <= q_item.width;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      count         <= '0;
      scanned       <= '0;
      need          <= '0;
      words_emitted <= '0;
      drop          <= 1'b0;
      has_word      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (words.ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (drop) begin
              if (q_item.last) begin
                drop          <= 1'b0;
                count         <= '0;
                scanned       <= '0;
                need          <= '0;
                words_emitted <= '0;
              end
            end else if (q_item.too_large) begin
              if (out_free) begin
                out_valid     <= 1'b1;
                out_word      <= '0;
                out_status    <= STATUS_TOO_LARGE;
                out_last      <= 1'b1;
                count         <= '0;
                scanned       <= '0;
                need          <= '0;
                words_emitted <= '0;
                drop          <= !q_item.last;
              end
            end else begin
              count  <= count_p1[4:0];
              last_r <= q_item.last;
              if (over_in) begin
                // Word is fixed by the entries before this one.
                fit   <= count;
                state <= ST_CAP;
              end else begin
                need    <= need_in;
                scanned <= count_p1[4:0];
                fit     <= count_p1[4:0];
                if (count_p1[4:0] == SLOTS || q_item.last) state <= ST_CAP;
              end
            end
          end
        end
        ST_SCAN: begin
          if (scanned == count) begin
            another <= (count == SLOTS) || (last_r && count != 5'd0);
            fit     <= count;
            state   <= ST_RESOLVE;
          end else if (prod_sc > PAYLOAD_LIMIT) begin
            another <= 1'b1;
            fit     <= scanned;
            state   <= ST_RESOLVE;
          end else begin
            need    <= need_sc;
            scanned <= scanned + 5'd1;
          end
        end
        ST_RESOLVE: begin
          // Release the held word once it is known whether more follow.
          if (!has_word || out_free) begin
            if (has_word) begin
              out_valid  <= 1'b1;
              out_word   <= word_r;
              out_status <= STATUS_OK;
              out_last   <= !another;
            end
            has_word <= 1'b0;
            if (another) begin
              state <= ST_CAP;
            end else begin
              state <= ST_IDLE;
              if (last_r) words_emitted <= '0;
            end
          end
        end
        ST_CAP: begin
          if (words_emitted >= capacity) begin
            if (out_free) begin
              out_valid     <= 1'b1;
              out_word      <= '0;
              out_status    <= STATUS_CAPACITY;
              out_last      <= 1'b1;
              count         <= '0;
              scanned       <= '0;
              need          <= '0;
              words_emitted <= '0;
              drop          <= !last_r;
              state         <= ST_IDLE;
            end
          end else begin
            row_r    <= cap_row;
            pack_n   <= cap_n;
            pack_b   <= row_bits(cap_row);
            pack_i   <= '0;
            pack_off <= '0;
            payload  <= '0;
            state    <= ST_PACK;
          end
        end
        ST_PACK: begin
          payload  <= payload_next;
          pack_off <= pack_off + pack_b;
          pack_i   <= pack_i + 5'd1;
          if (pack_i + 5'd1 == pack_n) begin
            word_r        <= {payload_next, row_r};
            has_word      <= 1'b1;
            head          <= slot_add(head, pack_n);
            count         <= count - pack_n;
            words_emitted <= words_emitted + 30'd1;
            scanned       <= '0;
            need          <= '0;
            state         <= ST_SCAN;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/s9wp_checker.sv -----
// Port-level checks on the packer output, bound to the top level.
`include "simple9_word_packer_top_assert.svh"

module s9wp_checker import s9wp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] code_word,
  input logic [1:0]  status,
  input logic        run_last
);

  `S9WP_CHECK_ALWAYS(a_reset_quiet, clk, rst, !out_valid, "output valid right after reset")
  `S9WP_CHECK_NEXT(a_hold_word, clk, rst, out_valid && !out_ready, out_valid && $stable(code_word) && $stable(status), "stalled word changed")
  `S9WP_CHECK(a_error_form, clk, rst, out_valid && status != STATUS_OK, code_word == 32'd0 && run_last, "error result not final or not zero")
  `S9WP_CHECK(a_row_range, clk, rst, out_valid && status == STATUS_OK, code_word[3:0] <= 4'd8, "selector row out of range")

endmodule

bind simple9_word_packer_top s9wp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (words.valid),
  .out_ready (words.ready),
  .code_word (words.code_word),
  .status    (words.status),
  .run_last  (words.run_last)
);
